### hdl/rrq_pkg.sv
// rrq_pkg: shared codes, command set and status bundle of the run queue scheduler
// used by rrq_ctrl, rrq_dp and round_robin_run_queue_top
`default_nettype none

package rrq_pkg;

   localparam int OP_W     = 2;
   localparam int SLOT_W   = 4;
   localparam int TSTATE_W = 2;
   localparam int STATUS_W = 2;
   localparam int CMD_W    = 5;

   localparam logic [OP_W-1:0] OP_ADD       = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE    = 2'd1;
   localparam logic [OP_W-1:0] OP_SET_STATE = 2'd2;
   localparam logic [OP_W-1:0] OP_SCHEDULE  = 2'd3;

   localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_IDLE   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_REJECT = 2'd2;

   localparam logic [TSTATE_W-1:0] TASK_READY   = 2'd0;
   localparam logic [TSTATE_W-1:0] TASK_RUNNING = 2'd1;

   // datapath micro-operations
   localparam logic [CMD_W-1:0] CMD_NONE          = 5'd0;
   localparam logic [CMD_W-1:0] CMD_CAPTURE       = 5'd1;
   localparam logic [CMD_W-1:0] CMD_REJECT        = 5'd2;
   localparam logic [CMD_W-1:0] CMD_IDLE          = 5'd3;
   localparam logic [CMD_W-1:0] CMD_ADD_FIRST     = 5'd4;
   localparam logic [CMD_W-1:0] CMD_ADD_RD_HEAD   = 5'd5;
   localparam logic [CMD_W-1:0] CMD_ADD_LINK      = 5'd6;
   localparam logic [CMD_W-1:0] CMD_ADD_HEAD      = 5'd7;
   localparam logic [CMD_W-1:0] CMD_REM_RD_SLOT   = 5'd8;
   localparam logic [CMD_W-1:0] CMD_REM_SINGLE    = 5'd9;
   localparam logic [CMD_W-1:0] CMD_REM_RD_HEAD   = 5'd10;
   localparam logic [CMD_W-1:0] CMD_REM_STEP      = 5'd11;
   localparam logic [CMD_W-1:0] CMD_REM_UNLINK    = 5'd12;
   localparam logic [CMD_W-1:0] CMD_SET_STATE     = 5'd13;
   localparam logic [CMD_W-1:0] CMD_SCHED_RD_HEAD = 5'd14;
   localparam logic [CMD_W-1:0] CMD_SCHED_STEP    = 5'd15;
   localparam logic [CMD_W-1:0] CMD_SCHED_PICK    = 5'd16;

   typedef struct packed {
      logic [CMD_W-1:0] code;
   } rrq_cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            add_reject;
      logic            rem_reject;
      logic            set_reject;
      logic            empty;
      logic            link_is_slot;
      logic            single;
      logic            state_ready;
      logic            link_is_head;
      logic            rsp_free;
   } rrq_status_type;

endpackage

`default_nettype wire

### hdl/rrq_ram.sv
// rrq_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module rrq_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 16
) (
   input  wire logic                       clock,
   input  wire logic                       we,
   input  wire logic [$clog2(DEPTH)-1:0]   waddr,
   input  wire logic [WIDTH-1:0]           wdata,
   input  wire logic                       re,
   input  wire logic [$clog2(DEPTH)-1:0]   raddr,
   output logic      [WIDTH-1:0]           rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem_ff[raddr];
      end
   end

endmodule

`default_nettype wire

### hdl/rrq_ctrl.sv
// rrq_ctrl: sequencing state machine of the run queue scheduler
// depends on rrq_pkg; drives rrq_dp through command codes
`default_nettype none

module rrq_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire rrq_pkg::rrq_status_type status,
   output rrq_pkg::rrq_cmd_type         cmd
);

   import rrq_pkg::*;

   localparam logic [2:0] S_IDLE       = 3'd0;
   localparam logic [2:0] S_DECODE     = 3'd1;
   localparam logic [2:0] S_ADD_LINK   = 3'd2;
   localparam logic [2:0] S_ADD_HEAD   = 3'd3;
   localparam logic [2:0] S_REM_NEXT   = 3'd4;
   localparam logic [2:0] S_REM_WALK   = 3'd5;
   localparam logic [2:0] S_SCHED_WALK = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_ready = (state_ff == S_IDLE) && status.rsp_free;

   always_comb begin
      state_in = state_ff;
      cmd.code = CMD_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.code = CMD_CAPTURE;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_IDLE;
            unique case (status.op)
               OP_ADD: begin
                  if (status.add_reject) begin
                     cmd.code = CMD_REJECT;
                  end else if (status.empty) begin
                     cmd.code = CMD_ADD_FIRST;
                  end else begin
                     cmd.code = CMD_ADD_RD_HEAD;
                     state_in = S_ADD_LINK;
                  end
               end
               OP_REMOVE: begin
                  if (status.rem_reject) begin
                     cmd.code = CMD_REJECT;
                  end else begin
                     cmd.code = CMD_REM_RD_SLOT;
                     state_in = S_REM_NEXT;
                  end
               end
               OP_SET_STATE: begin
                  cmd.code = status.set_reject ? CMD_REJECT : CMD_SET_STATE;
               end
               OP_SCHEDULE: begin
                  if (status.empty) begin
                     cmd.code = CMD_IDLE;
                  end else begin
                     cmd.code = CMD_SCHED_RD_HEAD;
                     state_in = S_SCHED_WALK;
                  end
               end
               default: cmd.code = CMD_REJECT;
            endcase
         end
         S_ADD_LINK: begin
            cmd.code = CMD_ADD_LINK;
            state_in = S_ADD_HEAD;
         end
         S_ADD_HEAD: begin
            cmd.code = CMD_ADD_HEAD;
            state_in = S_IDLE;
         end
         S_REM_NEXT: begin
            if (status.single) begin
               cmd.code = CMD_REM_SINGLE;
               state_in = S_IDLE;
            end else begin
               cmd.code = CMD_REM_RD_HEAD;
               state_in = S_REM_WALK;
            end
         end
         S_REM_WALK: begin
            if (status.link_is_slot) begin
               cmd.code = CMD_REM_UNLINK;
               state_in = S_IDLE;
            end else begin
               cmd.code = CMD_REM_STEP;
            end
         end
         S_SCHED_WALK: begin
            priority if (status.state_ready) begin
               cmd.code = CMD_SCHED_PICK;
               state_in = S_IDLE;
            end else if (status.link_is_head) begin
               cmd.code = CMD_IDLE;
               state_in = S_IDLE;
            end else begin
               cmd.code = CMD_SCHED_STEP;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

### hdl/rrq_dp.sv
// rrq_dp: run queue datapath: link and task state rams, queue flags, head and
// current registers, result register; depends on rrq_pkg and rrq_ram
`default_nettype none

module rrq_dp #(
   parameter int TASK_SLOTS = 16
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic [rrq_pkg::OP_W-1:0]         req_opcode,
   input  wire logic [rrq_pkg::SLOT_W-1:0]       req_slot,
   input  wire logic [rrq_pkg::TSTATE_W-1:0]     req_new_state,
   input  wire rrq_pkg::rrq_cmd_type             cmd,
   output rrq_pkg::rrq_status_type               status,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic      [rrq_pkg::STATUS_W-1:0]     rsp_status,
   output logic      [rrq_pkg::SLOT_W-1:0]       rsp_chosen_slot,
   output logic                                  rsp_switched
);

   import rrq_pkg::*;

   localparam int IDX_W = $clog2(TASK_SLOTS);

   logic [OP_W-1:0]       op_ff, op_in;
   logic [SLOT_W-1:0]     slot_ff, slot_in;
   logic [TSTATE_W-1:0]   ns_ff, ns_in;
   logic [IDX_W-1:0]      walk_ff, walk_in;
   logic [IDX_W-1:0]      nxt_ff, nxt_in;
   logic [IDX_W-1:0]      head_ff, head_in;
   logic                  nonempty_ff, nonempty_in;
   logic [IDX_W-1:0]      cur_ff, cur_in;
   logic                  cur_valid_ff, cur_valid_in;
   logic [TASK_SLOTS-1:0] queued_ff, queued_in;
   logic [TASK_SLOTS-1:0] sv_ff, sv_in;
   logic                  st_vld_ff, st_vld_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]   status_ff, status_in;
   logic [SLOT_W-1:0]     chosen_ff, chosen_in;
   logic                  switched_ff, switched_in;

   logic [IDX_W-1:0]    idx;
   logic                slot_ok;
   logic                rd_en;
   logic [IDX_W-1:0]    rd_addr;
   logic                link_we;
   logic [IDX_W-1:0]    link_waddr;
   logic [IDX_W-1:0]    link_wdata;
   logic [IDX_W-1:0]    link_rdata;
   logic                ts_we;
   logic [IDX_W-1:0]    ts_waddr;
   logic [TSTATE_W-1:0] ts_wdata;
   logic [TSTATE_W-1:0] ts_rdata;
   logic [TSTATE_W-1:0] ts_cur;

   assign idx     = IDX_W'(slot_ff);
   assign slot_ok = (32'(slot_ff) < TASK_SLOTS);
   assign ts_cur  = st_vld_ff ? ts_rdata : TASK_READY;

   rrq_ram #(
      .WIDTH (IDX_W),
      .DEPTH (TASK_SLOTS)
   ) u_link_ram (
      .clock (clock),
      .we    (link_we),
      .waddr (link_waddr),
      .wdata (link_wdata),
      .re    (rd_en),
      .raddr (rd_addr),
      .rdata (link_rdata)
   );

   rrq_ram #(
      .WIDTH (TSTATE_W),
      .DEPTH (TASK_SLOTS)
   ) u_state_ram (
      .clock (clock),
      .we    (ts_we),
      .waddr (ts_waddr),
      .wdata (ts_wdata),
      .re    (rd_en),
      .raddr (rd_addr),
      .rdata (ts_rdata)
   );

   always_comb begin
      status.op           = op_ff;
      status.add_reject   = !slot_ok || queued_ff[idx];
      status.rem_reject   = !slot_ok || !nonempty_ff || !queued_ff[idx];
      status.set_reject   = !slot_ok;
      status.empty        = !nonempty_ff;
      status.link_is_slot = (link_rdata == idx);
      status.single       = (head_ff == idx) && (link_rdata == idx);
      status.state_ready  = (ts_cur == TASK_READY);
      status.link_is_head = (link_rdata == head_ff);
      status.rsp_free     = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      op_in        = op_ff;
      slot_in      = slot_ff;
      ns_in        = ns_ff;
      walk_in      = walk_ff;
      nxt_in       = nxt_ff;
      head_in      = head_ff;
      nonempty_in  = nonempty_ff;
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      queued_in    = queued_ff;
      sv_in        = sv_ff;
      st_vld_in    = st_vld_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      status_in    = status_ff;
      chosen_in    = chosen_ff;
      switched_in  = switched_ff;
      rd_en        = 1'b0;
      rd_addr      = head_ff;
      link_we      = 1'b0;
      link_waddr   = idx;
      link_wdata   = idx;
      ts_we        = 1'b0;
      ts_waddr     = idx;
      ts_wdata     = ns_ff;
      unique case (cmd.code)
         CMD_NONE: begin
         end
         CMD_CAPTURE: begin
            op_in   = req_opcode;
            slot_in = req_slot;
            ns_in   = req_new_state;
         end
         CMD_REJECT, CMD_IDLE: begin
         end
         CMD_ADD_FIRST: begin
            link_we          = 1'b1;
            head_in          = idx;
            nonempty_in      = 1'b1;
            queued_in[idx]   = 1'b1;
         end
         CMD_ADD_RD_HEAD: begin
            rd_en = 1'b1;
         end
         CMD_ADD_LINK: begin
            link_we    = 1'b1;
            link_wdata = link_rdata;
         end
         CMD_ADD_HEAD: begin
            link_we        = 1'b1;
            link_waddr     = head_ff;
            queued_in[idx] = 1'b1;
         end
         CMD_REM_RD_SLOT: begin
            rd_en   = 1'b1;
            rd_addr = idx;
         end
         CMD_REM_SINGLE: begin
            nonempty_in    = 1'b0;
            head_in        = '0;
            queued_in[idx] = 1'b0;
         end
         CMD_REM_RD_HEAD: begin
            rd_en   = 1'b1;
            walk_in = head_ff;
            nxt_in  = link_rdata;
         end
         CMD_REM_STEP, CMD_SCHED_STEP: begin
            rd_en   = 1'b1;
            rd_addr = link_rdata;
            walk_in = link_rdata;
         end
         CMD_REM_UNLINK: begin
            link_we        = 1'b1;
            link_waddr     = walk_ff;
            link_wdata     = nxt_ff;
            queued_in[idx] = 1'b0;
            if (head_ff == idx) begin
               head_in = nxt_ff;
            end
         end
         CMD_SET_STATE: begin
            ts_we       = 1'b1;
            sv_in[idx]  = 1'b1;
         end
         CMD_SCHED_RD_HEAD: begin
            rd_en   = 1'b1;
            walk_in = head_ff;
         end
         CMD_SCHED_PICK: begin
            head_in        = walk_ff;
            cur_in         = walk_ff;
            cur_valid_in   = 1'b1;
            ts_we          = 1'b1;
            ts_waddr       = walk_ff;
            ts_wdata       = TASK_RUNNING;
            sv_in[walk_ff] = 1'b1;
         end
         default: begin
         end
      endcase

      if (rd_en) begin
         st_vld_in = sv_ff[rd_addr];
      end

      unique case (cmd.code)
         CMD_REJECT: begin
            rsp_valid_in = 1'b1;
            status_in    = ST_REJECT;
            chosen_in    = '0;
            switched_in  = 1'b0;
         end
         CMD_IDLE: begin
            rsp_valid_in = 1'b1;
            status_in    = ST_IDLE;
            chosen_in    = '0;
            switched_in  = 1'b0;
         end
         CMD_ADD_FIRST, CMD_ADD_HEAD, CMD_REM_SINGLE, CMD_REM_UNLINK, CMD_SET_STATE: begin
            rsp_valid_in = 1'b1;
            status_in    = ST_DONE;
            chosen_in    = '0;
            switched_in  = 1'b0;
         end
         CMD_SCHED_PICK: begin
            rsp_valid_in = 1'b1;
            status_in    = ST_DONE;
            chosen_in    = SLOT_W'(walk_ff);
            switched_in  = cur_valid_ff && (cur_ff != walk_ff);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         nonempty_ff  <= 1'b0;
         cur_ff       <= '0;
         cur_valid_ff <= 1'b0;
         queued_ff    <= '0;
         sv_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         nonempty_ff  <= nonempty_in;
         cur_ff       <= cur_in;
         cur_valid_ff <= cur_valid_in;
         queued_ff    <= queued_in;
         sv_ff        <= sv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      slot_ff     <= slot_in;
      ns_ff       <= ns_in;
      walk_ff     <= walk_in;
      nxt_ff      <= nxt_in;
      st_vld_ff   <= st_vld_in;
      status_ff   <= status_in;
      chosen_ff   <= chosen_in;
      switched_ff <= switched_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_chosen_slot = chosen_ff;
   assign rsp_switched    = switched_ff;

endmodule

`default_nettype wire

### hdl/round_robin_run_queue_top.sv
// round_robin_run_queue_top: round-robin task scheduler over a circular run queue
// depends on rrq_pkg, rrq_ctrl, rrq_dp and rrq_ram
//
// usage
//   req channel: one beat per operation (opcode, slot, new_state); opcodes are
//   add, remove, set task state and schedule. rsp channel: exactly one beat per
//   request (status, chosen_slot, switched), in request order.
//   one request is in flight at a time. set-state, rejects, schedule on an
//   empty queue and add to an empty queue answer from the decode state; add
//   otherwise reads the head's link, links the slot to it and then points the
//   head at the slot. remove reads the slot's link, then either drops the sole
//   entry or walks from the head to the slot's predecessor and unlinks the
//   slot. schedule walks from the head to the first ready task, or answers
//   idle after a full lap. the walks follow the next-slot ram one entry per
//   cycle through its registered read port. a new request is taken once the
//   result register is free or its beat is being taken in the same cycle; a
//   stalled rsp holds the result and blocks further requests.
//   reset empties the queue, marks every task ready and clears the current
//   task; the link ram needs no clearing, so the block is ready right after.
`default_nettype none

module round_robin_run_queue_top #(
   parameter int TASK_SLOTS = 16
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [rrq_pkg::OP_W-1:0]       req_opcode,
   input  wire logic [rrq_pkg::SLOT_W-1:0]     req_slot,
   input  wire logic [rrq_pkg::TSTATE_W-1:0]   req_new_state,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic      [rrq_pkg::STATUS_W-1:0]   rsp_status,
   output logic      [rrq_pkg::SLOT_W-1:0]     rsp_chosen_slot,
   output logic                                rsp_switched
);

   import rrq_pkg::*;

   rrq_cmd_type    cmd;
   rrq_status_type status;

   rrq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   rrq_dp #(
      .TASK_SLOTS (TASK_SLOTS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_opcode      (req_opcode),
      .req_slot        (req_slot),
      .req_new_state   (req_new_state),
      .cmd             (cmd),
      .status          (status),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_chosen_slot (rsp_chosen_slot),
      .rsp_switched    (rsp_switched)
   );

   // a request beat only lands when the result register can take its answer
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> !rsp_valid || rsp_ready)
      else $error("request taken while result register blocked");

   // one request in flight
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken during an operation");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status != 2'd3)
      else $error("undefined status code");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_DONE |-> rsp_chosen_slot == '0 && !rsp_switched)
      else $error("slot reported without a completed schedule");

endmodule

`default_nettype wire

### tb/sv/tb.sv
`timescale 1ns / 1ps
// tb: self-checking testbench for round_robin_run_queue_top, predicts each rsp beat
// from its own copy of the run queue; depends on rrq_pkg and round_robin_run_queue_top

module tb;
   import rrq_pkg::*;

   localparam int TASK_SLOTS  = 16;
   localparam int CYCLE_LIMIT = 400000;

   localparam logic [TSTATE_W-1:0] TASK_WAITING = 2'd2;
   localparam logic [TSTATE_W-1:0] TASK_ZOMBIE  = 2'd3;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   chosen;
      logic                switched;
   } rsp_beat_type;

   logic                clock         = 1'b0;
   logic                reset         = 1'b1;
   logic                req_valid     = 1'b0;
   logic [OP_W-1:0]     req_opcode    = OP_ADD;
   logic [SLOT_W-1:0]   req_slot      = '0;
   logic [TSTATE_W-1:0] req_new_state = TASK_READY;
   logic                rsp_ready     = 1'b0;
   logic                req_ready;
   logic                rsp_valid;
   logic [STATUS_W-1:0] rsp_status;
   logic [SLOT_W-1:0]   rsp_chosen_slot;
   logic                rsp_switched;

   // run queue as the scheduler should hold it
   logic [SLOT_W-1:0]   ring_next [TASK_SLOTS];
   logic                in_ring   [TASK_SLOTS];
   logic [TSTATE_W-1:0] task_st   [TASK_SLOTS];
   logic [SLOT_W-1:0]   head       = '0;
   logic                ring_busy  = 1'b0;
   logic [SLOT_W-1:0]   cur_task   = '0;
   logic                cur_known  = 1'b0;

   rsp_beat_type pending_rsp [$];
   int        failures      = 0;
   int        cycle_count   = 0;
   int        send_idle_pct = 0;
   int        rsp_stall_pct = 0;

   round_robin_run_queue_top #(.TASK_SLOTS(TASK_SLOTS)) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_opcode      (req_opcode),
      .req_slot        (req_slot),
      .req_new_state   (req_new_state),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_chosen_slot (rsp_chosen_slot),
      .rsp_switched    (rsp_switched)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      for (int k = 0; k < TASK_SLOTS; k++) begin
         ring_next[k] = '0;
         in_ring[k]   = 1'b0;
         task_st[k]   = TASK_READY;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("round_robin_run_queue_top verification failed");
         $finish;
      end
   end

   // applies one operation to the run queue and returns the beat it must produce
   function automatic rsp_beat_type sched_outcome(input logic [OP_W-1:0] op,
                                                  input logic [SLOT_W-1:0] s,
                                                  input logic [TSTATE_W-1:0] ns);
      rsp_beat_type      r;
      logic [SLOT_W-1:0] walk;
      logic              found;
      int                steps;
      r = '0;
      r.status = ST_DONE;
      case (op)
         OP_ADD: begin
            if (in_ring[s]) begin
               r.status = ST_REJECT;
            end else begin
               if (!ring_busy) begin
                  head = s;
                  ring_next[s] = s;
                  ring_busy = 1'b1;
               end else begin
                  ring_next[s] = ring_next[head];
                  ring_next[head] = s;
               end
               in_ring[s] = 1'b1;
            end
         end
         OP_REMOVE: begin
            if (!ring_busy || !in_ring[s]) begin
               r.status = ST_REJECT;
            end else if (head == s && ring_next[s] == s) begin
               ring_busy = 1'b0;
               head = '0;
               in_ring[s] = 1'b0;
            end else begin
               walk = head;
               steps = 0;
               while (steps < TASK_SLOTS && ring_next[walk] != s) begin
                  walk = ring_next[walk];
                  steps++;
               end
               if (ring_next[walk] != s) begin
                  r.status = ST_REJECT;
               end else begin
                  ring_next[walk] = ring_next[s];
                  if (head == s) head = ring_next[s];
                  in_ring[s] = 1'b0;
               end
            end
         end
         OP_SET_STATE: begin
            task_st[s] = ns;
         end
         OP_SCHEDULE: begin
            if (!ring_busy) begin
               r.status = ST_IDLE;
            end else begin
               walk = head;
               found = 1'b0;
               steps = 0;
               while (!found && steps < TASK_SLOTS) begin
                  if (task_st[walk] == TASK_READY) begin
                     found = 1'b1;
                  end else begin
                     walk = ring_next[walk];
                     steps++;
                     if (walk == head) steps = TASK_SLOTS;
                  end
               end
               if (!found) begin
                  r.status = ST_IDLE;
               end else begin
                  head = walk;
                  r.switched = cur_known && (cur_task != walk);
                  cur_task = walk;
                  cur_known = 1'b1;
                  task_st[walk] = TASK_RUNNING;
                  r.chosen = walk;
               end
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic logic [SLOT_W-1:0] pick_slot(input logic want_queued);
      logic [SLOT_W-1:0] s;
      int                n;
      s = SLOT_W'($urandom_range(0, TASK_SLOTS - 1));
      n = 0;
      while (n < TASK_SLOTS && in_ring[s] != want_queued) begin
         s = s + 1'b1;
         n++;
      end
      return s;
   endfunction

   always @(posedge clock) begin : rsp_monitor
      rsp_beat_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            $error("rsp beat with nothing expected: status %0d chosen_slot %0d switched %0d",
                   rsp_status, rsp_chosen_slot, rsp_switched);
            failures++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_status !== want.status) begin
               $error("status expected %0d actual %0d", want.status, rsp_status);
               failures++;
            end
            if (rsp_chosen_slot !== want.chosen) begin
               $error("chosen_slot expected %0d actual %0d", want.chosen, rsp_chosen_slot);
               failures++;
            end
            if (rsp_switched !== want.switched) begin
               $error("switched expected %0d actual %0d", want.switched, rsp_switched);
               failures++;
            end
         end
      end
      rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   task automatic send_op(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] s,
                          input logic [TSTATE_W-1:0] ns);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_opcode    <= op;
      req_slot      <= s;
      req_new_state <= ns;
      do @(posedge clock); while (!req_ready);
      pending_rsp.push_back(sched_outcome(op, s, ns));
   endtask

   task automatic wait_all_rsp;
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_rsp.size() != 0);
   endtask

   task automatic test_reset;
      reset <= 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   endtask

   task automatic test_directed_ops;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      send_op(OP_SCHEDULE, 4'd0, TASK_READY);
      send_op(OP_REMOVE, 4'd3, TASK_READY);
      send_op(OP_ADD, 4'd0, TASK_READY);
      send_op(OP_ADD, 4'd0, TASK_READY);
      send_op(OP_SCHEDULE, 4'd0, TASK_READY);
      send_op(OP_SCHEDULE, 4'd0, TASK_READY);
      send_op(OP_ADD, 4'd15, TASK_READY);
      send_op(OP_ADD, 4'd5, TASK_READY);
      send_op(OP_SCHEDULE, 4'd0, TASK_READY);
      send_op(OP_SET_STATE, 4'd15, TASK_ZOMBIE);
      send_op(OP_SET_STATE, 4'd0, TASK_WAITING);
      send_op(OP_SCHEDULE, 4'd0, TASK_READY);
      send_op(OP_SET_STATE, 4'd0, TASK_READY);
      send_op(OP_SCHEDULE, 4'd0, TASK_READY);
      send_op(OP_REMOVE, 4'd0, TASK_READY);
      send_op(OP_REMOVE, 4'd0, TASK_READY);
      send_op(OP_SET_STATE, 4'd0, TASK_READY);
      send_op(OP_ADD, 4'd0, TASK_READY);
      send_op(OP_SCHEDULE, 4'd10, TASK_ZOMBIE);
      send_op(OP_SET_STATE, 4'd10, TASK_RUNNING);
      send_op(OP_REMOVE, 4'd15, TASK_READY);
      send_op(OP_REMOVE, 4'd5, TASK_READY);
      send_op(OP_REMOVE, 4'd0, TASK_READY);
      send_op(OP_SCHEDULE, 4'd15, TASK_ZOMBIE);
      wait_all_rsp;
   endtask

   task automatic random_op;
      int                  pick;
      logic [SLOT_W-1:0]   s;
      logic [TSTATE_W-1:0] ns;
      pick = $urandom_range(0, 99);
      s    = SLOT_W'($urandom_range(0, TASK_SLOTS - 1));
      ns   = TSTATE_W'($urandom_range(0, 3));
      if (pick < 30) begin
         if ($urandom_range(0, 4) != 0) s = pick_slot(1'b0);
         send_op(OP_ADD, s, ns);
      end else if (pick < 50) begin
         if ($urandom_range(0, 4) != 0) s = pick_slot(1'b1);
         send_op(OP_REMOVE, s, ns);
      end else if (pick < 72) begin
         if ($urandom_range(0, 9) < 6) ns = TASK_READY;
         send_op(OP_SET_STATE, s, ns);
      end else begin
         send_op(OP_SCHEDULE, s, ns);
      end
      if ($urandom_range(0, 99) == 0) wait_all_rsp;
   endtask

   task automatic test_random_phases;
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 83; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 83; end
            default: begin send_idle_pct = 8; rsp_stall_pct = 8; end
         endcase
         for (int n = 0; n < 132; n++) random_op();
         wait_all_rsp;
      end
   endtask

   // every slot queued, one ready task: schedule walks the ring to it, and a second schedule walks a full lap
   task automatic test_full_ring;
      logic [SLOT_W-1:0]   keep;
      logic [TSTATE_W-1:0] ns;
      keep = SLOT_W'($urandom_range(0, TASK_SLOTS - 1));
      for (int k = 0; k < TASK_SLOTS; k++)
         if (!in_ring[k]) send_op(OP_ADD, k[SLOT_W-1:0], TSTATE_W'($urandom_range(0, 3)));
      for (int k = 0; k < TASK_SLOTS; k++) begin
         ns = (k[0]) ? TASK_WAITING : TASK_ZOMBIE;
         if (k == keep) ns = TASK_READY;
         send_op(OP_SET_STATE, k[SLOT_W-1:0], ns);
      end
      send_op(OP_SCHEDULE, SLOT_W'($urandom_range(0, 15)), TSTATE_W'($urandom_range(0, 3)));
      send_op(OP_SCHEDULE, SLOT_W'($urandom_range(0, 15)), TSTATE_W'($urandom_range(0, 3)));
      while (ring_busy) send_op(OP_REMOVE, pick_slot(1'b1), TSTATE_W'($urandom_range(0, 3)));
      wait_all_rsp;
   endtask

   initial begin
      test_reset();
      test_directed_ops();
      test_random_phases();
      test_full_ring();
      wait_all_rsp;
      repeat (40) @(posedge clock);
      if (failures == 0 && pending_rsp.size() == 0) begin
         $display("round_robin_run_queue_top verification clean");
      end else begin
         $display("round_robin_run_queue_top verification failed");
      end
      $finish;
   end

endmodule

### filelist.f
hdl/rrq_pkg.sv
hdl/rrq_ram.sv
hdl/rrq_ctrl.sv
hdl/rrq_dp.sv
hdl/round_robin_run_queue_top.sv
tb/sv/tb.sv
